// File: hdl/rk4sd_pkg.sv
// shared types, constants and arithmetic helpers of the rk4 spring-damper step unit
package rk4sd_pkg;

    localparam int DATA_W   = 32;
    localparam int WIDE_W   = 48;
    localparam int SUM_W    = 52;
    localparam int PROD_W   = 64;
    localparam int COEF_W   = 16;

    localparam logic [15:0] DAMP_RESET  = 16'd655;
    localparam logic [15:0] STIFF_RESET = 16'd10000;

    localparam logic [1:0] CFG_DAMPING   = 2'd0;
    localparam logic [1:0] CFG_STIFFNESS = 2'd1;

    localparam logic signed [63:0] WIDE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] WIDE_MIN = 64'shFFFF_8000_0000_0000;

    // final scaling: divide by 6 * 2^16 = 3 * 2^17
    localparam logic [63:0] SIXTH_HALF = 64'd196608;
    localparam logic [32:0] Y_CAP      = 33'd6442450947;   // 3 * 2^31 + 3
    localparam logic [33:0] RECIP3     = 34'd11453246123;  // ceil(2^35 / 3)

    typedef struct packed {
        logic signed [WIDE_W-1:0] val;
        logic                     hit;
    } t_clip;

    typedef struct packed {
        logic signed [DATA_W-1:0] tgt;
        logic signed [DATA_W-1:0] pos;
        logic signed [DATA_W-1:0] vel;
        logic [COEF_W-1:0]        dt;
        logic signed [WIDE_W-1:0] sp;
        logic signed [WIDE_W-1:0] sv;
        logic signed [WIDE_W-1:0] kx;
        logic signed [WIDE_W-1:0] kv;
        logic signed [SUM_W-1:0]  sum_x;
        logic signed [SUM_W-1:0]  sum_v;
        logic                     clip;
    } t_ctx;

    function automatic t_clip clip48(input logic signed [63:0] x);
        t_clip r;
        if (x > WIDE_MAX) begin
            r.val = WIDE_MAX[WIDE_W-1:0];
            r.hit = 1'b1;
        end else if (x < WIDE_MIN) begin
            r.val = WIDE_MIN[WIDE_W-1:0];
            r.hit = 1'b1;
        end else begin
            r.val = x[WIDE_W-1:0];
            r.hit = 1'b0;
        end
        return r;
    endfunction

    // signed 48-bit times unsigned 16-bit
    function automatic logic signed [63:0] mul_u16(input logic signed [WIDE_W-1:0] a,
                                                   input logic [COEF_W-1:0] b);
        logic signed [64:0] f;
        f = $signed({{17{a[WIDE_W-1]}}, a}) * $signed({49'd0, b});
        return f[63:0];
    endfunction

    // round to nearest, ties up, then floor shift
    function automatic logic signed [WIDE_W-1:0] rnd_shift(input logic signed [63:0] p,
                                                           input int s);
        logic signed [63:0] t;
        t = p + (64'sd1 <<< (s - 1));
        t = t >>> s;
        return t[WIDE_W-1:0];
    endfunction

endpackage

// File: hdl/rk4sd_stage.sv
// one runge-kutta stage: state step, damping product, spring force, weighted accumulate
module rk4sd_stage #(
    parameter bit FIRST    = 1'b0,
    parameter int STEP_SH  = 17,
    parameter int WEIGHT_SH = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [15:0]           i_damp,
    input  logic [15:0]           i_stiff,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  rk4sd_pkg::t_ctx       i_ctx,
    output logic                  o_valid,
    input  logic                  i_ready,
    output rk4sd_pkg::t_ctx       o_ctx
);
    import rk4sd_pkg::*;

    localparam int NS = 6;

    logic [NS-1:0]     r_vld;
    logic [NS-1:0]     rdy;
    t_ctx              r_c [NS];
    logic signed [63:0] r_pm_x, r_pm_v, r_pd, r_pa;

    t_ctx  n_c1, n_c3, n_c5;
    t_clip cl_sp, cl_sv, cl_d, cl_a;

    always_comb begin
        rdy[NS-1] = !r_vld[NS-1] || i_ready;
        for (int j = NS - 2; j >= 0; j--) begin
            rdy[j] = !r_vld[j] || rdy[j+1];
        end
    end
    assign o_ready = rdy[0];
    assign o_valid = r_vld[NS-1];
    assign o_ctx   = r_c[NS-1];

    always_comb begin
        // state stepped by the previous derivative
        n_c1  = r_c[0];
        cl_sp = clip48(64'(r_c[0].pos) + 64'(rnd_shift(r_pm_x, STEP_SH)));
        cl_sv = clip48(64'(r_c[0].vel) + 64'(rnd_shift(r_pm_v, STEP_SH)));
        if (FIRST) begin
            n_c1.sp = WIDE_W'(r_c[0].pos);
            n_c1.sv = WIDE_W'(r_c[0].vel);
        end else begin
            n_c1.sp   = cl_sp.val;
            n_c1.sv   = cl_sv.val;
            n_c1.clip = r_c[0].clip | cl_sp.hit | cl_sv.hit;
        end

        // spring deflection, held in kv until the force is formed
        n_c3      = r_c[2];
        cl_d      = clip48(64'(r_c[2].tgt) - 64'(r_c[2].sp) - 64'(rnd_shift(r_pd, 16)));
        n_c3.kv   = cl_d.val;
        n_c3.clip = r_c[2].clip | cl_d.hit;

        n_c5       = r_c[4];
        cl_a       = clip48(r_pa);
        n_c5.kx    = r_c[4].sv;
        n_c5.kv    = cl_a.val;
        n_c5.sum_x = r_c[4].sum_x + (SUM_W'(r_c[4].sv) <<< WEIGHT_SH);
        n_c5.sum_v = r_c[4].sum_v + (SUM_W'(cl_a.val) <<< WEIGHT_SH);
        n_c5.clip  = r_c[4].clip | cl_a.hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int j = 1; j < NS; j++) begin
                if (rdy[j]) begin
                    r_vld[j] <= r_vld[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_c[0] <= i_ctx;
            r_pm_x <= mul_u16(i_ctx.kx, i_ctx.dt);
            r_pm_v <= mul_u16(i_ctx.kv, i_ctx.dt);
        end
        if (rdy[1]) begin
            r_c[1] <= n_c1;
        end
        if (rdy[2]) begin
            r_c[2] <= r_c[1];
            r_pd   <= mul_u16(r_c[1].sv, i_damp);
        end
        if (rdy[3]) begin
            r_c[3] <= n_c3;
        end
        if (rdy[4]) begin
            r_c[4] <= r_c[3];
            r_pa   <= mul_u16(r_c[3].kv, i_stiff);
        end
        if (rdy[5]) begin
            r_c[5] <= n_c5;
        end
    end

endmodule

// File: hdl/rk4sd_scale.sv
// final scaling of the weighted sums by dt/6 with rounding and output saturation
module rk4sd_scale (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rk4sd_pkg::t_ctx      i_ctx,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_dpos,
    output logic signed [31:0]   o_dvel,
    output logic                 o_sat
);
    import rk4sd_pkg::*;

    localparam int NS = 5;

    logic [NS-1:0]            r_vld;
    logic [NS-1:0]            rdy;
    logic [COEF_W-1:0]        r_dt;
    logic                     r_clip [NS];
    logic signed [WIDE_W-1:0] r_s [2];
    logic signed [63:0]       r_prod [2];
    logic [32:0]              r_y [2];
    logic [31:0]              r_q [2];
    logic                     r_neg [2][2];
    logic signed [31:0]       r_out [2];

    t_clip       cl_s [2];
    logic [63:0] mag [2];
    logic [63:0] rx [2];
    logic [66:0] qm [2];
    logic [31:0] n_out [2];
    logic [1:0]  sat_hit;

    always_comb begin
        rdy[NS-1] = !r_vld[NS-1] || i_ready;
        for (int j = NS - 2; j >= 0; j--) begin
            rdy[j] = !r_vld[j] || rdy[j+1];
        end
    end
    assign o_ready = rdy[0];
    assign o_valid = r_vld[NS-1];
    assign o_dpos  = r_out[0];
    assign o_dvel  = r_out[1];
    assign o_sat   = r_clip[NS-1];

    always_comb begin
        cl_s[0] = clip48(64'(i_ctx.sum_x));
        cl_s[1] = clip48(64'(i_ctx.sum_v));
        for (int c = 0; c < 2; c++) begin
            mag[c] = r_prod[c][63] ? 64'(-r_prod[c]) : r_prod[c];
            rx[c]  = mag[c] + SIXTH_HALF;
            qm[c]  = 67'(r_y[c]) * 67'(RECIP3);
            if (!r_neg[c][1]) begin
                sat_hit[c] = r_q[c] > 32'h7FFF_FFFF;
                n_out[c]   = sat_hit[c] ? 32'h7FFF_FFFF : r_q[c];
            end else begin
                sat_hit[c] = r_q[c] > 32'h8000_0000;
                n_out[c]   = sat_hit[c] ? 32'h8000_0000 : (~r_q[c] + 32'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int j = 1; j < NS; j++) begin
                if (rdy[j]) begin
                    r_vld[j] <= r_vld[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_dt      <= i_ctx.dt;
            r_s[0]    <= cl_s[0].val;
            r_s[1]    <= cl_s[1].val;
            r_clip[0] <= i_ctx.clip | cl_s[0].hit | cl_s[1].hit;
        end
        if (rdy[1]) begin
            r_clip[1] <= r_clip[0];
            for (int c = 0; c < 2; c++) begin
                r_prod[c] <= mul_u16(r_s[c], r_dt);
            end
        end
        if (rdy[2]) begin
            r_clip[2] <= r_clip[1];
            for (int c = 0; c < 2; c++) begin
                r_neg[c][0] <= r_prod[c][63];
                r_y[c]      <= (rx[c][63:17] > 47'(Y_CAP)) ? Y_CAP : rx[c][49:17];
            end
        end
        if (rdy[3]) begin
            r_clip[3] <= r_clip[2];
            for (int c = 0; c < 2; c++) begin
                r_neg[c][1] <= r_neg[c][0];
                r_q[c]      <= qm[c][66:35];
            end
        end
        if (rdy[4]) begin
            r_clip[4] <= r_clip[3] | sat_hit[0] | sat_hit[1];
            for (int c = 0; c < 2; c++) begin
                r_out[c] <= n_out[c];
            end
        end
    end

endmodule

// File: hdl/rk4_spring_damper_step_unit.sv
// top level of the rk4 spring-damper step unit
// Fully pipelined RK4 step of a damped spring in Q16.16: one beat is accepted every
// cycle while o_stall is low; each beat passes four stage blocks of six registers
// each, then five registers of final scaling. Throughput is set by the pipeline
// alone: with no stall on the output a beat enters every cycle; a stall on the output
// fills empty slots first, so the input keeps taking beats until the pipe is full.
// Config writes (damping index 0, stiffness index 1) go straight to the working
// registers and must only be made while no beat is in flight.
module rk4_spring_damper_step_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_target_position,
    input  logic signed [31:0] i_position,
    input  logic signed [31:0] i_velocity,
    input  logic [15:0]        i_step_size,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_delta_position,
    output logic signed [31:0] o_delta_velocity,
    output logic               o_saturated
);
    import rk4sd_pkg::*;

    logic [15:0] r_damp;
    logic [15:0] r_stiff;

    // handshake chain between the blocks
    logic [4:0] vld;
    logic [4:0] rdy;
    t_ctx       ctx [5];

    // config registers, writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damp  <= DAMP_RESET;
            r_stiff <= STIFF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DAMPING:   r_damp  <= i_cfg_data;
                CFG_STIFFNESS: r_stiff <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // initial context: k1 sees the unstepped state
    always_comb begin
        ctx[0]       = '0;
        ctx[0].tgt   = i_target_position;
        ctx[0].pos   = i_position;
        ctx[0].vel   = i_velocity;
        ctx[0].dt    = i_step_size;
        ctx[0].sp    = WIDE_W'(i_position);
        ctx[0].sv    = WIDE_W'(i_velocity);
    end
    assign vld[0]  = i_valid;
    assign o_stall = !rdy[0];

    // k1: no step; k2, k3 stepped by dt/2; k4 by dt; k2 and k3 weighted twice
    rk4sd_stage #(.FIRST(1'b1), .STEP_SH(17), .WEIGHT_SH(0)) u_k1 (
        .i_clk, .i_rst_n, .i_damp(r_damp), .i_stiff(r_stiff),
        .i_valid(vld[0]), .o_ready(rdy[0]), .i_ctx(ctx[0]),
        .o_valid(vld[1]), .i_ready(rdy[1]), .o_ctx(ctx[1])
    );
    rk4sd_stage #(.FIRST(1'b0), .STEP_SH(17), .WEIGHT_SH(1)) u_k2 (
        .i_clk, .i_rst_n, .i_damp(r_damp), .i_stiff(r_stiff),
        .i_valid(vld[1]), .o_ready(rdy[1]), .i_ctx(ctx[1]),
        .o_valid(vld[2]), .i_ready(rdy[2]), .o_ctx(ctx[2])
    );
    rk4sd_stage #(.FIRST(1'b0), .STEP_SH(17), .WEIGHT_SH(1)) u_k3 (
        .i_clk, .i_rst_n, .i_damp(r_damp), .i_stiff(r_stiff),
        .i_valid(vld[2]), .o_ready(rdy[2]), .i_ctx(ctx[2]),
        .o_valid(vld[3]), .i_ready(rdy[3]), .o_ctx(ctx[3])
    );
    rk4sd_stage #(.FIRST(1'b0), .STEP_SH(16), .WEIGHT_SH(0)) u_k4 (
        .i_clk, .i_rst_n, .i_damp(r_damp), .i_stiff(r_stiff),
        .i_valid(vld[3]), .o_ready(rdy[3]), .i_ctx(ctx[3]),
        .o_valid(vld[4]), .i_ready(rdy[4]), .o_ctx(ctx[4])
    );

    // dt/6 scaling, rounding and output clip
    rk4sd_scale u_scale (
        .i_clk, .i_rst_n,
        .i_valid(vld[4]), .o_ready(rdy[4]), .i_ctx(ctx[4]),
        .o_valid(o_valid), .i_ready(!i_stall),
        .o_dpos(o_delta_position), .o_dvel(o_delta_velocity), .o_sat(o_saturated)
    );

endmodule
